/* hdl/corner_tangent_points_assert.svh */
// assertion macros shared by the corner tangent point queue and front pipeline
`ifndef CORNER_TANGENT_POINTS_ASSERT_SVH
`define CORNER_TANGENT_POINTS_ASSERT_SVH

// same-cycle implication
`define CTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ctp_pkg.sv */
// shared constants and types of the corner tangent point block
package ctp_pkg;

    localparam int LEN_EXTRA = 16;
    localparam int PULLBACK_RESET_UNITS = 10;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic shortened;
        logic degenerate_leg;
    } ctp_flags_t;

endpackage

/* hdl/ctp_if.sv */
// item channels of the corner tangent point block
interface ctp_in_if #(parameter int COORD_WIDTH = 24) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] final_x;
    logic signed [COORD_WIDTH-1:0] final_y;
    logic signed [COORD_WIDTH-1:0] corner_x;
    logic signed [COORD_WIDTH-1:0] corner_y;

    modport source (
        output valid, start_x, start_y, final_x, final_y, corner_x, corner_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, final_x, final_y, corner_x, corner_y,
        output ready
    );
endinterface

interface ctp_out_if #(parameter int COORD_WIDTH = 24) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] entry_x;
    logic signed [COORD_WIDTH-1:0] entry_y;
    logic signed [COORD_WIDTH-1:0] exit_x;
    logic signed [COORD_WIDTH-1:0] exit_y;
    logic                          shortened;
    logic                          degenerate_leg;

    modport source (
        output valid, entry_x, entry_y, exit_x, exit_y, shortened, degenerate_leg,
        input  ready
    );
    modport sink (
        input  valid, entry_x, entry_y, exit_x, exit_y, shortened, degenerate_leg,
        output ready
    );
endinterface

/* hdl/ctp_fifo.sv */
// short queue between the front and back pipelines
module ctp_fifo #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  full,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] pop_data,
    output logic                  not_empty
);
    import ctp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg;
    logic [PW-1:0]         wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg;
    logic [PW-1:0]         rd_ptr_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "corner_tangent_points_assert.svh"

    `CTP_ASSERT_NOW(a_count_bound, 1'b1, (count_reg <= CW'(DEPTH)), "queue count above depth")
    `CTP_ASSERT_NEXT(a_count_step, 1'b1, (count_reg == ($past(count_reg) + CW'($past(do_push)) - CW'($past(do_pop)))), "queue count out of step")
    `CTP_ASSERT_NOW(a_empty_ptrs, (count_reg == '0), (rd_ptr_reg == wr_ptr_reg), "empty queue with unequal pointers")

endmodule

/* hdl/ctp_front.sv */
// front pipeline: leg deltas, squares, shortening test, square roots, divisor setup
module ctp_front #(
    parameter int COORD_WIDTH = 24,
    localparam int LEG_WIDTH = 2 + 2 * COORD_WIDTH
        + 2 * (COORD_WIDTH + 1 + ctp_pkg::LEN_EXTRA) + 1,
    localparam int QUEUE_WIDTH = 2 * COORD_WIDTH + $bits(ctp_pkg::ctp_flags_t)
        + 2 * LEG_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ctp_in_if.sink                 item_in,
    input  logic [COORD_WIDTH-2:0] pullback,
    input  logic                   full,
    output logic                   push,
    output logic [QUEUE_WIDTH-1:0] push_data
);
    import ctp_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int SW = 2 * W + 1;
    localparam int LW = W + 1 + LEN_EXTRA;
    localparam int RW = 2 * LW - 1;
    localparam int BW = LW + 1;

    logic en;

    logic [DW-1:0] in_d   [4];
    logic [DW-1:0] in_neg [4];
    logic [W-1:0]  in_mag [4];

    logic          s1_v_reg;
    logic [W-1:0]  s1_cx_reg;
    logic [W-1:0]  s1_cy_reg;
    logic [3:0]    s1_sgn_reg;
    logic [W-1:0]  s1_mag_reg [4];

    logic          s2_v_reg;
    logic [W-1:0]  s2_cx_reg;
    logic [W-1:0]  s2_cy_reg;
    logic [3:0]    s2_sgn_reg;
    logic [W-1:0]  s2_mag_reg [4];
    logic [2*W-1:0] s2_sq_reg [4];
    logic [2*W-1:0] s2_lim_reg;
    logic [W-1:0]  dbl_pull;

    logic [SW-1:0] leg_sq [2];
    ctp_flags_t    s2_flags;

    logic          sq_v_reg    [LW+1];
    logic [W-1:0]  sq_cx_reg   [LW+1];
    logic [W-1:0]  sq_cy_reg   [LW+1];
    logic [3:0]    sq_sgn_reg  [LW+1];
    logic [W-1:0]  sq_mag_reg  [LW+1][4];
    ctp_flags_t    sq_flags_reg [LW+1];
    logic [RW-1:0] sq_rem_reg  [LW+1][2];
    logic [LW-1:0] sq_root_reg [LW+1][2];

    logic          fin_v_reg;
    logic [W-1:0]  fin_cx_reg;
    logic [W-1:0]  fin_cy_reg;
    logic [3:0]    fin_sgn_reg;
    logic [W-1:0]  fin_mag_reg [4];
    ctp_flags_t    fin_flags_reg;
    logic [LW-1:0] fin_a_reg [2];
    logic [BW-1:0] fin_b_reg [2];

    logic [LW-1:0] len_min;
    logic [LW-1:0] a_sel [2];
    logic [BW-1:0] b_sel [2];
    logic [LEG_WIDTH-1:0] leg_word [2];

    assign en            = !fin_v_reg || !full;
    assign item_in.ready = en;
    assign push          = fin_v_reg && !full;

    // deltas from the corner and their magnitudes
    always_comb
    begin
        in_d[0] = {item_in.start_x[W-1], item_in.start_x}
                - {item_in.corner_x[W-1], item_in.corner_x};
        in_d[1] = {item_in.start_y[W-1], item_in.start_y}
                - {item_in.corner_y[W-1], item_in.corner_y};
        in_d[2] = {item_in.final_x[W-1], item_in.final_x}
                - {item_in.corner_x[W-1], item_in.corner_x};
        in_d[3] = {item_in.final_y[W-1], item_in.final_y}
                - {item_in.corner_y[W-1], item_in.corner_y};
        for (int i = 0; i < 4; i++)
        begin
            in_neg[i] = '0 - in_d[i];
            in_mag[i] = in_d[i][DW-1] ? in_neg[i][W-1:0] : in_d[i][W-1:0];
        end
    end

    assign dbl_pull = {pullback, 1'b0};

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            leg_sq[k] = {1'b0, s2_sq_reg[2*k]} + {1'b0, s2_sq_reg[2*k+1]};
        end
        s2_flags.shortened = (leg_sq[0] <= {1'b0, s2_lim_reg})
                          || (leg_sq[1] <= {1'b0, s2_lim_reg});
        s2_flags.degenerate_leg = (leg_sq[0] == '0) || (leg_sq[1] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= item_in.valid;
            s2_v_reg    <= s1_v_reg;
            sq_v_reg[0] <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cx_reg  <= item_in.corner_x;
            s1_cy_reg  <= item_in.corner_y;
            for (int i = 0; i < 4; i++)
            begin
                s1_sgn_reg[i] <= in_d[i][DW-1];
                s1_mag_reg[i] <= in_mag[i];
            end
            s2_cx_reg  <= s1_cx_reg;
            s2_cy_reg  <= s1_cy_reg;
            s2_sgn_reg <= s1_sgn_reg;
            for (int i = 0; i < 4; i++)
            begin
                s2_mag_reg[i] <= s1_mag_reg[i];
                s2_sq_reg[i]  <= s1_mag_reg[i] * s1_mag_reg[i];
            end
            s2_lim_reg <= dbl_pull * dbl_pull;
            sq_cx_reg[0]    <= s2_cx_reg;
            sq_cy_reg[0]    <= s2_cy_reg;
            sq_sgn_reg[0]   <= s2_sgn_reg;
            sq_flags_reg[0] <= s2_flags;
            for (int i = 0; i < 4; i++)
            begin
                sq_mag_reg[0][i] <= s2_mag_reg[i];
            end
            for (int k = 0; k < 2; k++)
            begin
                sq_rem_reg[0][k]  <= {leg_sq[k], (2 * LEN_EXTRA)'(0)};
                sq_root_reg[0][k] <= '0;
            end
        end
    end

    // one root bit per stage
    for (genvar s = 0; s < LW; s++)
    begin : g_sqrt
        localparam int BIT = LW - 1 - s;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[s+1] <= sq_v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_cx_reg[s+1]    <= sq_cx_reg[s];
                sq_cy_reg[s+1]    <= sq_cy_reg[s];
                sq_sgn_reg[s+1]   <= sq_sgn_reg[s];
                sq_flags_reg[s+1] <= sq_flags_reg[s];
                for (int i = 0; i < 4; i++)
                begin
                    sq_mag_reg[s+1][i] <= sq_mag_reg[s][i];
                end
            end
        end

        for (genvar k = 0; k < 2; k++)
        begin : g_leg
            logic [RW-1:0] trial;
            logic          take;

            assign trial = (RW'(sq_root_reg[s][k]) << (BIT + 1)) | (RW'(1) << (2 * BIT));
            assign take  = (sq_rem_reg[s][k] >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[s+1][k]  <= take ? sq_rem_reg[s][k] - trial : sq_rem_reg[s][k];
                    sq_root_reg[s+1][k] <= sq_root_reg[s][k] | (take ? (LW'(1) << BIT) : '0);
                end
            end
        end
    end

    // scale factor and divisor per leg
    always_comb
    begin
        len_min = (sq_root_reg[LW][0] < sq_root_reg[LW][1])
                ? sq_root_reg[LW][0] : sq_root_reg[LW][1];
        for (int k = 0; k < 2; k++)
        begin
            if (sq_root_reg[LW][k] == '0)
            begin
                a_sel[k] = '0;
                b_sel[k] = BW'(1);
            end
            else if (sq_flags_reg[LW].shortened)
            begin
                a_sel[k] = len_min;
                b_sel[k] = {sq_root_reg[LW][k], 1'b0};
            end
            else
            begin
                a_sel[k] = LW'(pullback) << LEN_EXTRA;
                b_sel[k] = {1'b0, sq_root_reg[LW][k]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_v_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_v_reg <= sq_v_reg[LW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_cx_reg    <= sq_cx_reg[LW];
            fin_cy_reg    <= sq_cy_reg[LW];
            fin_sgn_reg   <= sq_sgn_reg[LW];
            fin_flags_reg <= sq_flags_reg[LW];
            for (int i = 0; i < 4; i++)
            begin
                fin_mag_reg[i] <= sq_mag_reg[LW][i];
            end
            for (int k = 0; k < 2; k++)
            begin
                fin_a_reg[k] <= a_sel[k];
                fin_b_reg[k] <= b_sel[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            leg_word[k] = {fin_sgn_reg[2*k], fin_sgn_reg[2*k+1], fin_mag_reg[2*k],
                           fin_mag_reg[2*k+1], fin_a_reg[k], fin_b_reg[k]};
        end
    end

    assign push_data = {fin_cx_reg, fin_cy_reg, fin_flags_reg, leg_word[1], leg_word[0]};

`include "corner_tangent_points_assert.svh"

    `CTP_ASSERT_NOW(a_degen_short, (push && fin_flags_reg.degenerate_leg), fin_flags_reg.shortened, "zero leg without shortening")
    `CTP_ASSERT_NOW(a_div0_nonzero, push, (fin_b_reg[0] != '0), "zero divisor on entry leg")
    `CTP_ASSERT_NOW(a_div1_nonzero, push, (fin_b_reg[1] != '0), "zero divisor on exit leg")

endmodule

/* hdl/ctp_back.sv */
// back pipeline: offset products, rounded divisions, tangent point sums
module ctp_back #(
    parameter int COORD_WIDTH = 24,
    localparam int LEG_WIDTH = 2 + 2 * COORD_WIDTH
        + 2 * (COORD_WIDTH + 1 + ctp_pkg::LEN_EXTRA) + 1,
    localparam int QUEUE_WIDTH = 2 * COORD_WIDTH + $bits(ctp_pkg::ctp_flags_t)
        + 2 * LEG_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [QUEUE_WIDTH-1:0] q_data,
    output logic                   q_pop,
    ctp_out_if.source              item_out
);
    import ctp_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int LW  = W + 1 + LEN_EXTRA;
    localparam int BW  = LW + 1;
    localparam int DDW = LW + 2;
    localparam int ASP = (LW + 1) / 2;
    localparam int AHW = LW - ASP;
    localparam int NW  = W + LW + 2;
    localparam int FW  = $bits(ctp_flags_t);

    logic en;

    logic [W-1:0]  u_cx;
    logic [W-1:0]  u_cy;
    ctp_flags_t    u_flags;
    logic [3:0]    u_sgn;
    logic [W-1:0]  u_mag [4];
    logic [LW-1:0] u_a [2];
    logic [BW-1:0] u_b [2];

    logic           m_v_reg;
    logic [W-1:0]   m_cx_reg;
    logic [W-1:0]   m_cy_reg;
    ctp_flags_t     m_flags_reg;
    logic [3:0]     m_sgn_reg;
    logic [W+ASP-1:0] m_pl_reg [4];
    logic [W+AHW-1:0] m_ph_reg [4];
    logic [BW-1:0]  m_b_reg [2];
    logic [NW-1:0]  n_sum [4];

    logic           dv_v_reg     [W+1];
    logic [W-1:0]   dv_cx_reg    [W+1];
    logic [W-1:0]   dv_cy_reg    [W+1];
    ctp_flags_t     dv_flags_reg [W+1];
    logic [3:0]     dv_sgn_reg   [W+1];
    logic [NW-1:0]  dv_rem_reg   [W+1][4];
    logic [W-1:0]   dv_q_reg     [W+1][4];
    logic [DDW-1:0] dv_d_reg     [W+1][2];

    logic           out_v_reg;
    logic [W-1:0]   out_pt_reg [4];
    ctp_flags_t     out_flags_reg;
    logic [W:0]     pt_sum [4];
    logic [W:0]     q_ext [4];

    assign en    = !out_v_reg || item_out.ready;
    assign q_pop = q_valid && en;

    // queue word fields
    assign u_cx    = q_data[2*LEG_WIDTH+FW+W +: W];
    assign u_cy    = q_data[2*LEG_WIDTH+FW +: W];
    assign u_flags = q_data[2*LEG_WIDTH +: FW];

    for (genvar k = 0; k < 2; k++)
    begin : g_unpack
        logic [LEG_WIDTH-1:0] leg;

        assign leg          = q_data[k*LEG_WIDTH +: LEG_WIDTH];
        assign u_b[k]       = leg[0 +: BW];
        assign u_a[k]       = leg[BW +: LW];
        assign u_mag[2*k+1] = leg[BW+LW +: W];
        assign u_mag[2*k]   = leg[BW+LW+W +: W];
        assign u_sgn[2*k+1] = leg[BW+LW+2*W];
        assign u_sgn[2*k]   = leg[BW+LW+2*W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg     <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg     <= q_pop;
            dv_v_reg[0] <= m_v_reg;
        end
    end

    // split products, then rounding numerator and doubled divisor
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            n_sum[i] = (NW'(m_ph_reg[i]) << ASP) + NW'(m_pl_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_cx_reg    <= u_cx;
            m_cy_reg    <= u_cy;
            m_flags_reg <= u_flags;
            m_sgn_reg   <= u_sgn;
            for (int i = 0; i < 4; i++)
            begin
                m_pl_reg[i] <= u_mag[i] * u_a[i/2][ASP-1:0];
                m_ph_reg[i] <= u_mag[i] * u_a[i/2][LW-1:ASP];
            end
            for (int k = 0; k < 2; k++)
            begin
                m_b_reg[k] <= u_b[k];
            end
            dv_cx_reg[0]    <= m_cx_reg;
            dv_cy_reg[0]    <= m_cy_reg;
            dv_flags_reg[0] <= m_flags_reg;
            dv_sgn_reg[0]   <= m_sgn_reg;
            for (int i = 0; i < 4; i++)
            begin
                dv_rem_reg[0][i] <= (n_sum[i] << 1) + NW'(m_b_reg[i/2]);
                dv_q_reg[0][i]   <= '0;
            end
            for (int k = 0; k < 2; k++)
            begin
                dv_d_reg[0][k] <= {m_b_reg[k], 1'b0};
            end
        end
    end

    // one quotient bit per stage
    for (genvar s = 0; s < W; s++)
    begin : g_div
        localparam int BIT = W - 1 - s;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[s+1] <= dv_v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_cx_reg[s+1]    <= dv_cx_reg[s];
                dv_cy_reg[s+1]    <= dv_cy_reg[s];
                dv_flags_reg[s+1] <= dv_flags_reg[s];
                dv_sgn_reg[s+1]   <= dv_sgn_reg[s];
                for (int k = 0; k < 2; k++)
                begin
                    dv_d_reg[s+1][k] <= dv_d_reg[s][k];
                end
            end
        end

        for (genvar i = 0; i < 4; i++)
        begin : g_lane
            logic [NW-1:0] trial;
            logic          take;

            assign trial = NW'(dv_d_reg[s][i/2]) << BIT;
            assign take  = (dv_rem_reg[s][i] >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[s+1][i] <= take ? dv_rem_reg[s][i] - trial : dv_rem_reg[s][i];
                    dv_q_reg[s+1][i]   <= dv_q_reg[s][i] | (take ? (W'(1) << BIT) : '0);
                end
            end
        end
    end

    // corner plus signed offset
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            q_ext[i] = dv_sgn_reg[W][i] ? ('0 - {1'b0, dv_q_reg[W][i]}) : {1'b0, dv_q_reg[W][i]};
            if (i % 2 == 0)
            begin
                pt_sum[i] = {dv_cx_reg[W][W-1], dv_cx_reg[W]} + q_ext[i];
            end
            else
            begin
                pt_sum[i] = {dv_cy_reg[W][W-1], dv_cy_reg[W]} + q_ext[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_flags_reg <= dv_flags_reg[W];
            for (int i = 0; i < 4; i++)
            begin
                out_pt_reg[i] <= pt_sum[i][W-1:0];
            end
        end
    end

    assign item_out.valid          = out_v_reg;
    assign item_out.entry_x        = out_pt_reg[0];
    assign item_out.entry_y        = out_pt_reg[1];
    assign item_out.exit_x         = out_pt_reg[2];
    assign item_out.exit_y         = out_pt_reg[3];
    assign item_out.shortened      = out_flags_reg.shortened;
    assign item_out.degenerate_leg = out_flags_reg.degenerate_leg;

endmodule

/* hdl/corner_tangent_points.sv */
// top level of the corner tangent point block
// Takes one item per clock cycle and delivers one result item per clock cycle
// when the output side keeps up. The design holds two bit-per-stage pipelines:
// the square root of each leg (COORD_WIDTH + 17 stages) in the front part and
// the four rounded divisions (COORD_WIDTH stages) in the back part. A
// four-item queue sits between them, so each part stalls on its own.
// The pullback register resets to 10.0 and is written through cfg_we/cfg_wdata;
// the user must write it only while idle, which the block itself does not enforce.
module corner_tangent_points #(
    parameter int COORD_WIDTH   = 24,
    parameter int FRACTION_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ctp_in_if.sink                 item_in,
    ctp_out_if.source              item_out,
    input  logic                   cfg_we,
    input  logic [COORD_WIDTH-2:0] cfg_wdata
);
    import ctp_pkg::*;

    localparam int PW = COORD_WIDTH - 1;
    localparam int LEG_WIDTH = 2 + 2 * COORD_WIDTH + 2 * (COORD_WIDTH + 1 + LEN_EXTRA) + 1;
    localparam int QUEUE_WIDTH = 2 * COORD_WIDTH + $bits(ctp_flags_t) + 2 * LEG_WIDTH;
    localparam logic [PW-1:0] PULL_RESET = PW'(PULLBACK_RESET_UNITS << FRACTION_BITS);

    logic [PW-1:0]          pullback_reg;
    logic                   push;
    logic [QUEUE_WIDTH-1:0] push_data;
    logic                   full;
    logic                   pop;
    logic [QUEUE_WIDTH-1:0] pop_data;
    logic                   not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pullback_reg <= PULL_RESET;
        end
        else if (cfg_we)
        begin
            pullback_reg <= cfg_wdata;
        end
    end

    ctp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .pullback  (pullback_reg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    ctp_fifo #(
        .DATA_WIDTH (QUEUE_WIDTH),
        .DEPTH      (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    ctp_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (not_empty),
        .q_data   (pop_data),
        .q_pop    (pop),
        .item_out (item_out)
    );

endmodule

/* tb/ctp_tb_if.sv */
// result item type of the corner tangent point testbench
`timescale 1ns / 1ps
package ctp_tb_types;
    typedef struct {
        logic signed [23:0] entry_x;
        logic signed [23:0] entry_y;
        logic signed [23:0] exit_x;
        logic signed [23:0] exit_y;
        logic               shortened;
        logic               degenerate_leg;
    } tangent_result_t;
endpackage

/* tb/tb_top.sv */
// testbench of the corner tangent point block: predicted tangent points checked in order
`timescale 1ns / 1ps
module tb_top;
    import ctp_pkg::*;
    import ctp_tb_types::*;

    localparam int CW = 24;
    localparam int LATENCY = 2 * CW + 25;
    localparam int LIMIT_CYCLES = 600000;

    class tangent_scoreboard;
        tangent_result_t pending[$];
        int errors;

        function logic signed [63:0] round_scale(logic signed [63:0] delta,
                                                 logic [127:0] num, logic [127:0] den);
            logic [127:0] m;
            logic [127:0] q;
            m = delta < 0 ? 128'(-delta) : 128'(delta);
            q = (m * num * 2 + den) / (2 * den);
            return delta < 0 ? -$signed(64'(q)) : $signed(64'(q));
        endfunction

        function logic [63:0] isqrt(logic [127:0] x);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 63; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (128'(t) * 128'(t) <= x)
                    r = t;
            end
            return r;
        endfunction

        function void note_corner(logic [22:0] pull, logic signed [CW-1:0] sx,
                                  logic signed [CW-1:0] sy, logic signed [CW-1:0] fx,
                                  logic signed [CW-1:0] fy, logic signed [CW-1:0] cx,
                                  logic signed [CW-1:0] cy);
            logic signed [63:0] dx[2];
            logic signed [63:0] dy[2];
            logic signed [63:0] ox[2];
            logic signed [63:0] oy[2];
            logic [127:0] sq[2];
            logic [63:0] len[2];
            logic [127:0] lim;
            logic [63:0] lmin;
            logic short_leg;
            tangent_result_t r;
            dx[0] = sx - cx; dy[0] = sy - cy;
            dx[1] = fx - cx; dy[1] = fy - cy;
            r.degenerate_leg = 0;
            for (int k = 0; k < 2; k++)
            begin
                sq[k] = 128'(dx[k] * dx[k]) + 128'(dy[k] * dy[k]);
                len[k] = isqrt(sq[k] << 32);
                if (sq[k] == 0)
                    r.degenerate_leg = 1;
            end
            lim = 128'(2 * pull) * 128'(2 * pull);
            short_leg = sq[0] <= lim || sq[1] <= lim;
            lmin = len[0] < len[1] ? len[0] : len[1];
            for (int k = 0; k < 2; k++)
            begin
                ox[k] = 0; oy[k] = 0;
                if (len[k] != 0)
                begin
                    if (short_leg)
                    begin
                        ox[k] = round_scale(dx[k], lmin, 2 * 128'(len[k]));
                        oy[k] = round_scale(dy[k], lmin, 2 * 128'(len[k]));
                    end
                    else
                    begin
                        ox[k] = round_scale(dx[k], 128'(pull) << 16, len[k]);
                        oy[k] = round_scale(dy[k], 128'(pull) << 16, len[k]);
                    end
                end
            end
            r.entry_x = CW'(cx + ox[0]);
            r.entry_y = CW'(cy + oy[0]);
            r.exit_x = CW'(cx + ox[1]);
            r.exit_y = CW'(cy + oy[1]);
            r.shortened = short_leg;
            pending.insert(pending.size(), r);
        endfunction

        function void check_points(tangent_result_t got);
            tangent_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.entry_x !== e.entry_x)
            begin
                $error("entry_x expected %0d actual %0d", e.entry_x, got.entry_x); errors++;
            end
            if (got.entry_y !== e.entry_y)
            begin
                $error("entry_y expected %0d actual %0d", e.entry_y, got.entry_y); errors++;
            end
            if (got.exit_x !== e.exit_x)
            begin
                $error("exit_x expected %0d actual %0d", e.exit_x, got.exit_x); errors++;
            end
            if (got.exit_y !== e.exit_y)
            begin
                $error("exit_y expected %0d actual %0d", e.exit_y, got.exit_y); errors++;
            end
            if (got.shortened !== e.shortened)
            begin
                $error("shortened expected %0d actual %0d", e.shortened, got.shortened);
                errors++;
            end
            if (got.degenerate_leg !== e.degenerate_leg)
            begin
                $error("degenerate_leg expected %0d actual %0d", e.degenerate_leg,
                       got.degenerate_leg);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CW-2:0] cfg_wdata = 0;
    logic [22:0] pullback = 23'(PULLBACK_RESET_UNITS << 8);
    logic quiet = 0;
    logic hold_long = 0;
    int cycles = 0;
    tangent_scoreboard sb = new();

    ctp_in_if #(.COORD_WIDTH(CW)) in_ch();
    ctp_out_if #(.COORD_WIDTH(CW)) out_ch();

    corner_tangent_points #(.COORD_WIDTH(CW), .FRACTION_BITS(8)) dut (
        .clk(clk), .rst_n(rst_n), .item_in(in_ch.sink), .item_out(out_ch.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.start_x = 0; in_ch.start_y = 0; in_ch.final_x = 0;
        in_ch.final_y = 0; in_ch.corner_x = 0; in_ch.corner_y = 0;
        out_ch.ready = 0;
    end

    // receiver with random stall bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_ch.ready <= 0;
                repeat (300) @(posedge clk);
                hold_long = 0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 16);
                out_ch.ready <= 0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        tangent_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.entry_x = out_ch.entry_x;
            got.entry_y = out_ch.entry_y;
            got.exit_x = out_ch.exit_x;
            got.exit_y = out_ch.exit_y;
            got.shortened = out_ch.shortened;
            got.degenerate_leg = out_ch.degenerate_leg;
            sb.check_points(got);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_corner(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                               logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
                               logic signed [CW-1:0] cx, logic signed [CW-1:0] cy);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 16);
            in_ch.valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.start_x <= sx; in_ch.start_y <= sy;
        in_ch.final_x <= fx; in_ch.final_y <= fy;
        in_ch.corner_x <= cx; in_ch.corner_y <= cy;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_corner(pullback, sx, sy, fx, fy, cx, cy);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_pullback(logic [22:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        pullback = v;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(0, 8000)) - 4000);
            default: return CW'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic random_phase(int count, int mode);
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        for (int i = 0; i < count; i++)
        begin
            if (mode == 0)
            begin
                send_corner(rand_coord(0), rand_coord(0), rand_coord(0),
                            rand_coord(0), rand_coord(0), rand_coord(0));
            end
            else
            begin
                // points near a corner within +-2000000, offsets kept in range
                cx = CW'($signed($urandom_range(0, 4000000)) - 2000000);
                cy = CW'($signed($urandom_range(0, 4000000)) - 2000000);
                if ($urandom_range(0, 15) == 0)
                    send_corner(cx, cy, cx + rand_coord(mode), cy + rand_coord(mode), cx, cy);
                else
                    send_corner(cx + rand_coord(mode), cy + rand_coord(mode),
                                cx + rand_coord(mode), cy + rand_coord(mode), cx, cy);
            end
        end
    endtask

    localparam logic signed [CW-1:0] MAXC = 24'sh7fffff;
    localparam logic signed [CW-1:0] MINC = 24'sh800000;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed corners at the reset pullback
        send_corner(0, 0, 0, 0, 0, 0);
        send_corner(MAXC, 0, 0, 0, 0, 0);
        send_corner(0, 0, 0, MAXC, 0, 0);
        send_corner(MAXC, MAXC, MINC, MINC, 0, 0);
        send_corner(MINC, MINC, MAXC, MAXC, MAXC, MINC);
        send_corner(MAXC, MINC, MINC, MAXC, MINC, MAXC);
        send_corner(-1, -1, 1, 1, 0, 0);
        send_corner(10000, 0, 0, 10000, 0, 0);
        send_corner(5120, 0, 0, 5121, 0, 0);
        send_corner(5121, 0, 0, 5121, 0, 0);
        send_corner(3, 4, -5, 12, 0, 0);
        send_corner(100, 200, 300, 400, 100, 200);
        drain();
        write_pullback(0);
        send_corner(1000, 0, 0, 1000, 0, 0);
        send_corner(0, 0, 1000, 0, 0, 0);
        drain();
        write_pullback(23'h7fffff);
        send_corner(MAXC, MAXC, MINC, MINC, 0, 0);
        send_corner(MINC, 0, 0, MAXC, 0, 0);
        random_phase(80, 0);
        drain();
        write_pullback(1);
        send_corner(7, 0, 0, 9, 0, 0);
        send_corner(2, 0, 0, 2, 0, 0);
        random_phase(100, 1);
        drain();
        write_pullback(23'(PULLBACK_RESET_UNITS << 8));
        // long receiver stall while items keep coming
        hold_long = 1;
        random_phase(120, 2);
        drain();
        write_pullback(23'($urandom_range(1, 30000)));
        random_phase(120, 1);
        random_phase(40, 0);
        drain();
        write_pullback(23'($urandom_range(0, 23'h7fffff)));
        random_phase(60, 0);
        drain();
        write_pullback(23'($urandom_range(100, 3000)));
        quiet = 1;
        random_phase(100, 2);
        drain();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/ctp_pkg.sv
hdl/ctp_if.sv
hdl/ctp_fifo.sv
hdl/ctp_front.sv
hdl/ctp_back.sv
hdl/corner_tangent_points.sv
tb/ctp_tb_if.sv
tb/tb_top.sv
